// ----- rtl/segment_intersection_point_macros.svh -----
// Assertion macros used by the checker file of the segment intersection block.
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SIP_ASSERT_IMPLY(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion lbl failed");

// Condition that must never be true outside reset.
`define SIP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion lbl failed");

`endif

// ----- rtl/sip_pkg.sv -----
// Package with widths, payload types and pipeline types of the segment intersection block.
`default_nettype none
package sip_pkg;
    localparam int W  = 32;         // coordinate width
    localparam int DW = 2 * W + 3;  // width of a cross product
    localparam int QB = W + 2;      // quotient bits produced by the divider
    localparam int PW = 3 * W + 4;  // width of the dividend |dir| * tn
    localparam int H  = W + 2;      // low slice of tn for the split multiply
    localparam int SIP_LATENCY = QB + 7;

    typedef struct packed {
        logic signed [W-1:0] seg_a_start_x;
        logic signed [W-1:0] seg_a_start_y;
        logic signed [W-1:0] seg_a_end_x;
        logic signed [W-1:0] seg_a_end_y;
        logic signed [W-1:0] seg_b_start_x;
        logic signed [W-1:0] seg_b_start_y;
        logic signed [W-1:0] seg_b_end_x;
        logic signed [W-1:0] seg_b_end_y;
    } t_in;

    typedef struct packed {
        logic                hit;
        logic signed [W-1:0] cross_x;
        logic signed [W-1:0] cross_y;
    } t_out;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] low;
        logic [QB-1:0] q;
    } t_lane;

    typedef struct packed {
        logic [DW-1:0]       den;
        t_lane               lx;
        t_lane               ly;
        logic signed [W-1:0] ax;
        logic signed [W-1:0] ay;
        logic                negx;
        logic                negy;
        logic                hit;
    } t_div;
endpackage
`default_nettype wire

// ----- rtl/segment_intersection_point.sv -----
// Top level: fully pipelined intersection point of two 2D segments.
// Pipeline: 7 stages plus 34 divide steps from the accepting edge to the result strobe.
// Throughput: one transaction per cycle; busy stays low, the result strobe cannot be held off.
// The divider takes one quotient bit per stage, which sets the pipeline depth.
// Reset clears all valid bits synchronously; no result appears until new inputs arrive.
`default_nettype none
module segment_intersection_point (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire sip_pkg::t_in i_in,
    output logic              o_valid,
    output sip_pkg::t_out     o_out
);
    localparam int W  = sip_pkg::W;
    localparam int DW = sip_pkg::DW;
    localparam int QB = sip_pkg::QB;
    localparam int PW = sip_pkg::PW;
    localparam int H  = sip_pkg::H;
    localparam int RW = DW + 7;
    localparam int SW = W + 4;

    assign busy = 1'b0;

    logic [6:1] r_v;

    // Stage 1: direction and offset vectors.
    logic signed [W:0]   r_dax, r_day, r_dbx, r_dby, r_cx, r_cy;
    logic signed [W-1:0] r_ax1, r_ay1;
    // Stage 2: products.
    logic signed [2*W+1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [W:0]     r_dax2, r_day2;
    logic signed [W-1:0]   r_ax2, r_ay2;
    // Stage 3: cross products.
    logic signed [DW-1:0] r_den, r_tn, r_un;
    logic signed [W:0]    r_dax3, r_day3;
    logic signed [W-1:0]  r_ax3, r_ay3;
    // Stage 4: sign normalized.
    logic [DW-1:0]       r_den4, r_tn4, r_un4;
    logic                r_nz4;
    logic [W:0]          r_adx4, r_ady4;
    logic                r_negx4, r_negy4;
    logic signed [W-1:0] r_ax4, r_ay4;
    // Stage 5: range check and partial products.
    logic                    r_hit5;
    logic [DW-1:0]           r_den5;
    logic [2*W+2:0]          r_plx5, r_ply5;
    logic [2*W+1:0]          r_phx5, r_phy5;
    logic                    r_negx5, r_negy5;
    logic signed [W-1:0]     r_ax5, r_ay5;
    // Stage 6: divider input.
    sip_pkg::t_div r_d6;
    sip_pkg::t_out r_out;
    logic          r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dax <= {i_in.seg_a_end_x[W-1], i_in.seg_a_end_x}
               - {i_in.seg_a_start_x[W-1], i_in.seg_a_start_x};
        r_day <= {i_in.seg_a_end_y[W-1], i_in.seg_a_end_y}
               - {i_in.seg_a_start_y[W-1], i_in.seg_a_start_y};
        r_dbx <= {i_in.seg_b_end_x[W-1], i_in.seg_b_end_x}
               - {i_in.seg_b_start_x[W-1], i_in.seg_b_start_x};
        r_dby <= {i_in.seg_b_end_y[W-1], i_in.seg_b_end_y}
               - {i_in.seg_b_start_y[W-1], i_in.seg_b_start_y};
        r_cx  <= {i_in.seg_b_start_x[W-1], i_in.seg_b_start_x}
               - {i_in.seg_a_start_x[W-1], i_in.seg_a_start_x};
        r_cy  <= {i_in.seg_b_start_y[W-1], i_in.seg_b_start_y}
               - {i_in.seg_a_start_y[W-1], i_in.seg_a_start_y};
        r_ax1 <= i_in.seg_a_start_x;
        r_ay1 <= i_in.seg_a_start_y;

        r_p0   <= r_dax * r_dby;
        r_p1   <= r_day * r_dbx;
        r_p2   <= r_cx * r_dby;
        r_p3   <= r_cy * r_dbx;
        r_p4   <= r_cx * r_day;
        r_p5   <= r_cy * r_dax;
        r_dax2 <= r_dax;
        r_day2 <= r_day;
        r_ax2  <= r_ax1;
        r_ay2  <= r_ay1;

        r_den  <= DW'(r_p0) - DW'(r_p1);
        r_tn   <= DW'(r_p2) - DW'(r_p3);
        r_un   <= DW'(r_p4) - DW'(r_p5);
        r_dax3 <= r_dax2;
        r_day3 <= r_day2;
        r_ax3  <= r_ax2;
        r_ay3  <= r_ay2;

        // A negative denominator flips all three so that den is positive.
        r_nz4   <= (r_den != '0);
        r_den4  <= r_den[DW-1] ? -r_den : r_den;
        r_tn4   <= r_den[DW-1] ? -r_tn  : r_tn;
        r_un4   <= r_den[DW-1] ? -r_un  : r_un;
        r_adx4  <= r_dax3[W] ? -r_dax3 : r_dax3;
        r_ady4  <= r_day3[W] ? -r_day3 : r_day3;
        r_negx4 <= r_dax3[W];
        r_negy4 <= r_day3[W];
        r_ax4   <= r_ax3;
        r_ay4   <= r_ay3;

        // The stretch of 1.01 turns the parameter range into [0, 101/100].
        r_hit5  <= r_nz4 && !r_tn4[DW-1] && !r_un4[DW-1]
                   && (RW'(r_tn4) * RW'(100) <= RW'(r_den4) * RW'(101))
                   && (RW'(r_un4) * RW'(100) <= RW'(r_den4) * RW'(101));
        r_den5  <= r_den4;
        r_plx5  <= (2*W+3)'(r_adx4) * (2*W+3)'(r_tn4[H-1:0]);
        r_ply5  <= (2*W+3)'(r_ady4) * (2*W+3)'(r_tn4[H-1:0]);
        r_phx5  <= (2*W+2)'(r_adx4) * (2*W+2)'(r_tn4[DW-1:H]);
        r_phy5  <= (2*W+2)'(r_ady4) * (2*W+2)'(r_tn4[DW-1:H]);
        r_negx5 <= r_negx4;
        r_negy5 <= r_negy4;
        r_ax5   <= r_ax4;
        r_ay5   <= r_ay4;
    end

    logic [PW-1:0] w_nx, w_ny;
    assign w_nx = PW'(r_plx5) + (PW'(r_phx5) << H);
    assign w_ny = PW'(r_ply5) + (PW'(r_phy5) << H);

    always_ff @(posedge i_clk) begin
        r_d6.den    <= r_den5;
        r_d6.lx.rem <= DW'(w_nx[PW-1:QB]);
        r_d6.lx.low <= w_nx[QB-1:0];
        r_d6.lx.q   <= '0;
        r_d6.ly.rem <= DW'(w_ny[PW-1:QB]);
        r_d6.ly.low <= w_ny[QB-1:0];
        r_d6.ly.q   <= '0;
        r_d6.ax     <= r_ax5;
        r_d6.ay     <= r_ay5;
        r_d6.negx   <= r_negx5;
        r_d6.negy   <= r_negy5;
        r_d6.hit    <= r_hit5;
    end

    sip_pkg::t_div w_d [QB+1];
    logic          w_v [QB+1];
    assign w_d[0] = r_d6;
    assign w_v[0] = r_v[6];

    for (genvar g = 0; g < QB; g++) begin : g_div
        sip_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .i_d     (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    function automatic logic [W-1:0] place(logic signed [W-1:0] base, logic neg,
                                           logic [QB-1:0] q);
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] off;
        off = SW'(q);
        sum = {{(SW-W){base[W-1]}}, base} + (neg ? -off : off);
        if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
            return sum[W-1:0];
        end else if (sum[SW-1]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    sip_pkg::t_out n_out;
    always_comb begin
        n_out.hit     = w_d[QB].hit;
        n_out.cross_x = '0;
        n_out.cross_y = '0;
        if (w_d[QB].hit) begin
            n_out.cross_x = place(w_d[QB].ax, w_d[QB].negx, w_d[QB].lx.q);
            n_out.cross_y = place(w_d[QB].ay, w_d[QB].negy, w_d[QB].ly.q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= w_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;
endmodule
`default_nettype wire

// ----- rtl/sip_div_stage.sv -----
// One restoring division step for both coordinate lanes, with its pipeline register.
`default_nettype none
module sip_div_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sip_pkg::t_div i_d,
    output logic               o_valid,
    output sip_pkg::t_div      o_d
);
    function automatic sip_pkg::t_lane step(sip_pkg::t_lane l, logic [sip_pkg::DW-1:0] den);
        logic [sip_pkg::DW:0] trial;
        sip_pkg::t_lane       r;
        trial = {l.rem, l.low[sip_pkg::QB-1]};
        r.low = {l.low[sip_pkg::QB-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
            r.rem = sip_pkg::DW'(trial - {1'b0, den});
            r.q   = {l.q[sip_pkg::QB-2:0], 1'b1};
        end else begin
            r.rem = trial[sip_pkg::DW-1:0];
            r.q   = {l.q[sip_pkg::QB-2:0], 1'b0};
        end
        return r;
    endfunction

    sip_pkg::t_div n_d;
    sip_pkg::t_div r_d;
    logic          r_valid;

    always_comb begin
        n_d    = i_d;
        n_d.lx = step(i_d.lx, i_d.den);
        n_d.ly = step(i_d.ly, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule
`default_nettype wire

// ----- rtl/sip_checker.sv -----
// Port-level checker for the segment intersection block and its bind.
`default_nettype none
`include "segment_intersection_point_macros.svh"
module sip_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_valid,
    input wire sip_pkg::t_out o_out
);
    `SIP_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)
    `SIP_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, (o_valid && !o_out.hit) |-> (o_out.cross_x == '0 && o_out.cross_y == '0))
    `SIP_ASSERT_IMPLY(a_result_follows, i_clk, i_rst_n, (start && !busy) |-> ##(sip_pkg::SIP_LATENCY) o_valid)
    `SIP_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(start && !busy, sip_pkg::SIP_LATENCY))
endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the segment intersection point block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int N_RANDOM    = 580;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_POINT = 300;
    localparam int MAXC        = 32'h7fffffff;
    localparam int MINC        = 32'h80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    sip_pkg::t_in  i_in = '0;
    logic o_valid;
    sip_pkg::t_out o_out;

    sip_pkg::t_in  seg_pair_q[$];
    sip_pkg::t_out expected_point_q[$];
    int   error_count = 0;
    int   sent_count = 0;
    int   total_items = 0;
    int   hit_count = 0;
    int   miss_count = 0;
    int   cycle_count = 0;
    int   gap_left = 0;
    logic took = 1'b0;
    logic drained = 1'b0;

    segment_intersection_point u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always #10 i_clk = ~i_clk;

    // Exact intersection in wide integers; the 1.01 stretch becomes a bound of 101/100 on t and u.
    function automatic sip_pkg::t_out intersect_point(sip_pkg::t_in s);
        logic signed [127:0] ax, ay, dax, day, dbx, dby, cx, cy, den, tn, un, px, py;
        sip_pkg::t_out r;
        r = '0;
        ax  = s.seg_a_start_x;
        ay  = s.seg_a_start_y;
        dax = 128'(s.seg_a_end_x) - ax;
        day = 128'(s.seg_a_end_y) - ay;
        dbx = 128'(s.seg_b_end_x) - 128'(s.seg_b_start_x);
        dby = 128'(s.seg_b_end_y) - 128'(s.seg_b_start_y);
        cx  = 128'(s.seg_b_start_x) - ax;
        cy  = 128'(s.seg_b_start_y) - ay;
        den = dax * dby - day * dbx;
        if (den == 0) return r;
        tn = cx * dby - cy * dbx;
        un = cx * day - cy * dax;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        if (tn < 0 || un < 0 || tn * 100 > den * 101 || un * 100 > den * 101) return r;
        // Signed division truncates toward zero, as the point rounding requires.
        px = ax + (dax * tn) / den;
        py = ay + (day * tn) / den;
        if (px > 128'(MAXC)) px = 128'(MAXC);
        if (px < 128'(MINC)) px = 128'(MINC);
        if (py > 128'(MAXC)) py = 128'(MAXC);
        if (py < 128'(MINC)) py = 128'(MINC);
        r.hit     = 1'b1;
        r.cross_x = px[31:0];
        r.cross_y = py[31:0];
        return r;
    endfunction

    task automatic add_pair(input int asx, input int asy, input int aex, input int aey,
                            input int bsx, input int bsy, input int bex, input int bey);
        sip_pkg::t_in s;
        s.seg_a_start_x = asx;
        s.seg_a_start_y = asy;
        s.seg_a_end_x   = aex;
        s.seg_a_end_y   = aey;
        s.seg_b_start_x = bsx;
        s.seg_b_start_y = bsy;
        s.seg_b_end_x   = bex;
        s.seg_b_end_y   = bey;
        seg_pair_q = {seg_pair_q, s};
    endtask

    function automatic int coord_in(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Result check and transaction capture.
    always @(posedge i_clk) begin
        sip_pkg::t_out want;
        cycle_count <= cycle_count + 1;
        took <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            if (expected_point_q.size() == 0) begin
                report_mismatch("unexpected result, hit", o_out.hit, 0);
            end else begin
                want = expected_point_q.pop_front();
                if (o_out.hit !== want.hit) report_mismatch("hit", o_out.hit, want.hit);
                if (o_out.cross_x !== want.cross_x)
                    report_mismatch("cross_x", o_out.cross_x, want.cross_x);
                if (o_out.cross_y !== want.cross_y)
                    report_mismatch("cross_y", o_out.cross_y, want.cross_y);
                if (want.hit) hit_count++;
                else miss_count++;
            end
        end
        if (i_rst_n && start && !busy) begin
            expected_point_q = {expected_point_q, intersect_point(i_in)};
            sent_count++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus driver, changes inputs on the falling edge.
    always @(negedge i_clk) begin
        logic hold;
        hold = 1'b0;
        if (i_rst_n) begin
            if (took) begin
                void'(seg_pair_q.pop_front());
                gap_left = (sent_count >= 150 && sent_count < 250) ? 0 : $urandom_range(0, 7);
            end
            if (start && !took) begin
                hold = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (sent_count == DRAIN_POINT && !drained) begin
                // Let the pipeline empty completely once before continuing.
                if (expected_point_q.size() == 0) drained = 1'b1;
            end else if (seg_pair_q.size() > 0) begin
                hold = 1'b1;
                i_in <= seg_pair_q[0];
            end
        end
        start <= hold;
    end

    initial begin
        int asx, asy, dx, dy, k, span;
        // Directed cases: degenerate, extremes, parallel, endpoints, the 1.01 bound, saturation.
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
        add_pair(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC);
        add_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        add_pair(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC);
        add_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
        add_pair(0, 0, 65536, 0, 0, 65536, 65536, 65536);
        add_pair(0, 0, 65536, 65536, 131072, 131072, 196608, 196608);
        add_pair(-65536, 0, 65536, 0, 0, -65536, 0, 65536);
        add_pair(0, 0, 65536, 0, 0, 0, 0, 65536);
        add_pair(0, 0, 65536, 0, 65536, -5, 65536, 5);
        add_pair(0, 0, 100, 0, 101, -10, 101, 10);
        add_pair(0, 0, 100, 0, 102, -10, 102, 10);
        add_pair(0, 0, 100, 0, -1, -10, -1, 10);
        add_pair(0, 0, 3, 0, 1, -7, 1, 5);
        add_pair(0, 0, -3, 0, -1, -7, -1, 5);
        add_pair(0, 0, 3, 7, 2, -1, 0, 9);
        add_pair(MAXC - 199, -199, MAXC, 0, MAXC - 201, 203, MAXC - 1, 3);
        add_pair(MINC + 199, 199, MINC, 0, MINC + 201, -203, MINC + 1, -3);
        add_pair(7, 9, 7, 9, 0, 0, 100, 100);
        for (k = 0; k < N_RANDOM; k++) begin
            k = k;
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_pair($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                end
                2: begin
                    // Parallel or collinear pair.
                    asx = coord_in(1 << 20);
                    asy = coord_in(1 << 20);
                    dx  = coord_in(1 << 18);
                    dy  = coord_in(1 << 18);
                    span = $urandom_range(0, 3);
                    add_pair(asx, asy, asx + dx, asy + dy, asx + span * dy, asy - span * dx,
                             asx + span * dy + 2 * dx, asy - span * dx + 2 * dy);
                end
                3: begin
                    // Endpoints near the edges of the range, where saturation shows.
                    span = 1 << $urandom_range(4, 20);
                    asx = ($urandom_range(0, 1) ? MAXC : MINC) + ($urandom_range(0, 1) ?
                          -int'($urandom_range(0, span)) : int'($urandom_range(0, span)));
                    asy = coord_in(span);
                    add_pair(asx, asy, asx + coord_in(span) / 2, asy + coord_in(span),
                             asx + coord_in(span) / 2, asy + coord_in(span),
                             asx + coord_in(span) / 2, asy + coord_in(span));
                end
                default: begin
                    // Segments in a shared box cross often.
                    span = 1 << $urandom_range(2, 30);
                    asx = coord_in(span / 2);
                    asy = coord_in(span / 2);
                    add_pair(coord_in(span / 2), coord_in(span / 2), coord_in(span / 2),
                             coord_in(span / 2), asx, asy, coord_in(span / 2), coord_in(span / 2));
                end
            endcase
        end
        total_items = seg_pair_q.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (sent_count == total_items);
        wait (expected_point_q.size() == 0);
        repeat (sip_pkg::SIP_LATENCY + 10) @(posedge i_clk);
        if (expected_point_q.size() != 0) begin
            $display("ERROR: %0d results never arrived", expected_point_q.size());
            error_count++;
        end
        $display("Sent %0d segment pairs: %0d hits and %0d misses checked.",
                 sent_count, hit_count, miss_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
